### sv/lir_pkg.sv
package lir_pkg;

  localparam int SAMPLE_BITS_DEF = 24;
  localparam int LENGTH_BITS_DEF = 24;

  // Both rate registers are 19 bits wide, enough for 384 kHz.
  localparam int RATE_BITS = 19;
  localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(44100);

  localparam int MAX_UPSAMPLE_RATIO = 16;
  localparam int RATIO_BITS = $clog2(MAX_UPSAMPLE_RATIO + 1);

  // Upper bound on the results that one input sample may produce.
  localparam int MAX_RESULTS = 34;
  localparam int RES_BITS = $clog2(MAX_RESULTS + 1);

  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] REG_OLD_RATE    = CFG_IDX_BITS'(0);
  localparam logic [CFG_IDX_BITS-1:0] REG_NEW_RATE    = CFG_IDX_BITS'(1);
  localparam logic [CFG_IDX_BITS-1:0] REG_CLIP_LENGTH = CFG_IDX_BITS'(2);

  localparam logic [1:0] EMIT_PASS   = 2'd0;
  localparam logic [1:0] EMIT_ERR    = 2'd1;
  localparam logic [1:0] EMIT_TAIL   = 2'd2;
  localparam logic [1:0] EMIT_INTERP = 2'd3;

  function automatic int maxi(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  typedef struct packed {
    logic       latch_in;
    logic       mul_len;
    logic       go_total;
    logic       save_total;
    logic       go_step;
    logic       save_step;
    logic       mul_interp;
    logic       sum;
    logic       go_sample;
    logic       emit;
    logic [1:0] emit_sel;
    logic       advance;
    logic       pass_finish;
    logic       finish;
  } lir_cmd_t;

  typedef struct packed {
    logic len_zero;
    logic pass_mode;
    logic ratio_err;
    logic first_in;
    logic in_last;
    logic more;
    logic tail;
    logic interp_ok;
    logic div_busy;
    logic out_free;
  } lir_status_t;

endpackage

### sv/linear_interp_resampler_top.sv
// Channel   Handshake               Payload
// input     in_valid / in_ready     sample_in
// output    out_valid / out_ready   sample_out, last_out, rate_error
// config    cfg_we (no wait)        cfg_index, cfg_data
//
// One sample is taken at a time. Each interpolated output passes through
// the shared one-bit-per-cycle divider; the first sample of a clip first runs
// two more divisions, of LENGTH_BITS + 5 and 19 quotient bits.
// Reset restores both rates to 44100 and the clip length to zero.
// A result waits in the output register; while it is stalled the next result
// holds the block, and a new input is taken once the current one is done.
module linear_interp_resampler_top import lir_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0]                 cfg_index,
  input  logic [maxi(RATE_BITS, LENGTH_BITS)-1:0] cfg_data,
  input  logic                                    in_valid,
  output logic                                    in_ready,
  input  logic signed [SAMPLE_BITS-1:0]           sample_in,
  output logic                                    out_valid,
  input  logic                                    out_ready,
  output logic signed [SAMPLE_BITS-1:0]           sample_out,
  output logic                                    last_out,
  output logic                                    rate_error
);

  lir_cmd_t    cmd;
  lir_status_t status;

  lir_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  lir_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .sample_in  (sample_in),
    .cmd        (cmd),
    .status     (status),
    .out_ready  (out_ready),
    .out_valid  (out_valid),
    .sample_out (sample_out),
    .last_out   (last_out),
    .rate_error (rate_error)
  );

endmodule

### sv/lir_div.sv
module lir_div #(
  parameter int D_W = 20,
  parameter int Q_W = 29,
  parameter int CNT_W = 5
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [D_W-1:0]   rem_init,
  input  logic [Q_W-1:0]   low_init,
  input  logic [D_W-1:0]   divisor_in,
  input  logic [CNT_W-1:0] iters,
  output logic             busy,
  output logic [Q_W-1:0]   quotient,
  output logic [D_W-1:0]   remainder
);

  logic [D_W-1:0]   divisor;
  logic [D_W-1:0]   rem;
  logic [Q_W-1:0]   low;
  logic [CNT_W-1:0] cnt;
  logic [D_W:0]     trial;
  logic [D_W:0]     diff;
  logic             take;

  // Restoring division, one quotient bit per cycle. The dividend bits still
  // to be brought down sit at the top of low; quotient bits enter at the bottom.
  assign trial = {rem, low[Q_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign take  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CNT_W'(1)) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem     <= rem_init;
      low     <= low_init;
      divisor <= divisor_in;
      cnt     <= iters;
    end else if (busy) begin
      rem <= take ? diff[D_W-1:0] : trial[D_W-1:0];
      low <= {low[Q_W-2:0], take};
      cnt <= cnt - CNT_W'(1);
    end
  end

  assign quotient  = low;
  assign remainder = rem;

endmodule

### sv/lir_dp.sv
module lir_dp import lir_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]                  cfg_index,
  input  logic [maxi(RATE_BITS, LENGTH_BITS)-1:0]  cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]            sample_in,
  input  lir_cmd_t                                 cmd,
  output lir_status_t                              status,
  input  logic                                     out_ready,
  output logic                                     out_valid,
  output logic signed [SAMPLE_BITS-1:0]            sample_out,
  output logic                                     last_out,
  output logic                                     rate_error
);

  localparam int S          = SAMPLE_BITS;
  localparam int L          = LENGTH_BITS;
  localparam int R          = RATE_BITS;
  localparam int COUNT_BITS = L + RATIO_BITS;
  localparam int LEFT_W     = maxi(L, R) + 1;
  localparam int CMP_W      = LEFT_W + 1;
  localparam int PL_W       = L + R;
  localparam int NC_W       = L + R + 2;
  localparam int PA_W       = S + R + 1;
  localparam int PD_W       = S + R + 2;
  localparam int NUM_W      = S + R + 3;
  localparam int DIV_D      = R + 1;
  localparam int DIV_Q      = maxi(COUNT_BITS, maxi(S, R));
  localparam int CNT_W      = $clog2(DIV_Q + 1);
  localparam int RR_W       = R + RATIO_BITS;

  // Configuration registers.
  logic [R-1:0] old_rate;
  logic [R-1:0] new_rate;
  logic [L-1:0] clip_length;

  // Clip progress.
  logic signed [S-1:0] prev_sample;
  logic [L-1:0]          inputs_seen;
  logic [COUNT_BITS-1:0] outputs_sent;
  logic [COUNT_BITS-1:0] total_outputs;
  logic [LEFT_W-1:0]     left_pos;
  logic [R-1:0]          phase_rem;
  logic [RES_BITS-1:0]   n_results;

  // Working registers.
  logic signed [S-1:0]     cur_sample;
  logic [PL_W-1:0]         prod_len;
  logic [R-1:0]            step_q;
  logic [R-1:0]            step_r;
  logic signed [PA_W-1:0]  prod_a;
  logic signed [PD_W-1:0]  prod_d;
  logic signed [NUM_W-1:0] num;

  logic [NC_W-1:0]   cnt_dividend;
  logic              num_neg;
  logic [NUM_W-1:0]  num_mag;
  logic signed [R:0] new_s;
  logic signed [R:0] rem_s;
  logic signed [S:0] diff_s;
  logic [S-1:0]      q_s;
  logic [S-1:0]      interp_val;
  logic [R:0]        rem_sum;
  logic              wrap;
  logic [R-1:0]      rem_next;
  logic [LEFT_W-1:0] left_next;
  logic              sent_last;

  logic             div_start;
  logic [DIV_D-1:0] div_rem_init;
  logic [DIV_Q-1:0] div_low_init;
  logic [DIV_D-1:0] div_divisor;
  logic [CNT_W-1:0] div_iters;
  logic             div_busy;
  logic [DIV_Q-1:0] div_quot;
  logic [DIV_D-1:0] div_rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      old_rate    <= RATE_RESET;
      new_rate    <= RATE_RESET;
      clip_length <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_OLD_RATE:    old_rate    <= cfg_data[R-1:0];
        REG_NEW_RATE:    new_rate    <= cfg_data[R-1:0];
        REG_CLIP_LENGTH: clip_length <= cfg_data[L-1:0];
        default: ;
      endcase
    end
  end

  // Status toward the controller.
  assign status.len_zero  = clip_length == '0;
  assign status.pass_mode = (old_rate == '0) || (new_rate == '0) || (old_rate == new_rate);
  assign status.ratio_err = RR_W'(new_rate) > RR_W'(old_rate) * RR_W'(MAX_UPSAMPLE_RATIO);
  assign status.first_in  = inputs_seen == '0;
  assign status.in_last   = ((L + 1)'(inputs_seen) + (L + 1)'(1)) == (L + 1)'(clip_length);
  assign status.more      = (outputs_sent < total_outputs) &&
                            (n_results < RES_BITS'(MAX_RESULTS));
  assign status.tail      = (CMP_W'(left_pos) + CMP_W'(1)) >= CMP_W'(clip_length);
  assign status.interp_ok = (CMP_W'(left_pos) + CMP_W'(1)) == CMP_W'(inputs_seen);
  assign status.div_busy  = div_busy;
  assign status.out_free  = !out_valid || out_ready;

  // Position of the next output, stepped by old_rate/new_rate.
  assign rem_sum   = {1'b0, phase_rem} + {1'b0, step_r};
  assign wrap      = rem_sum >= {1'b0, new_rate};
  assign rem_next  = wrap ? R'(rem_sum - {1'b0, new_rate}) : rem_sum[R-1:0];
  assign left_next = left_pos + LEFT_W'(step_q) + LEFT_W'(wrap);
  assign sent_last = ((COUNT_BITS + 1)'(outputs_sent) + (COUNT_BITS + 1)'(1)) ==
                     (COUNT_BITS + 1)'(total_outputs);

  always_ff @(posedge clk) begin
    if (rst || cfg_we) begin
      prev_sample   <= '0;
      inputs_seen   <= '0;
      outputs_sent  <= '0;
      total_outputs <= '0;
      left_pos      <= '0;
      phase_rem     <= '0;
    end else begin
      if (cmd.save_total) begin
        total_outputs <= div_quot[COUNT_BITS-1:0];
      end
      if (cmd.advance) begin
        outputs_sent <= outputs_sent + COUNT_BITS'(1);
        left_pos     <= left_next;
        phase_rem    <= rem_next;
      end
      if (cmd.finish || cmd.pass_finish) begin
        if (status.in_last) begin
          prev_sample   <= '0;
          inputs_seen   <= '0;
          outputs_sent  <= '0;
          total_outputs <= '0;
          left_pos      <= '0;
          phase_rem     <= '0;
        end else begin
          inputs_seen <= inputs_seen + L'(1);
          if (cmd.finish) begin
            prev_sample <= cur_sample;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n_results <= '0;
    end else if (cmd.latch_in) begin
      n_results <= '0;
    end else if (cmd.advance) begin
      n_results <= n_results + RES_BITS'(1);
    end
  end

  // Arithmetic working registers.
  assign new_s  = $signed({1'b0, new_rate});
  assign rem_s  = $signed({1'b0, phase_rem});
  assign diff_s = (S + 1)'(cur_sample) - (S + 1)'(prev_sample);

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cur_sample <= sample_in;
    end
    if (cmd.mul_len) begin
      prod_len <= PL_W'(clip_length) * PL_W'(new_rate);
    end
    if (cmd.save_step) begin
      step_q <= div_quot[R-1:0];
      step_r <= div_rem[R-1:0];
    end
    if (cmd.mul_interp) begin
      prod_a <= PA_W'(prev_sample) * PA_W'(new_s);
      prod_d <= PD_W'(diff_s) * PD_W'(rem_s);
    end
    if (cmd.sum) begin
      num <= NUM_W'(prod_a) + NUM_W'(prod_d);
    end
  end

  // The interpolated value is trunc(num / new_rate): divide the magnitude
  // and restore the sign.
  assign num_neg      = num[NUM_W-1];
  assign num_mag      = num_neg ? NUM_W'(-num) : NUM_W'(num);
  assign cnt_dividend = (NC_W'(prod_len) << 1) + NC_W'(old_rate);
  assign q_s          = div_quot[S-1:0];
  assign interp_val   = num_neg ? S'(-q_s) : q_s;

  // Each division is aligned so that its quotient fits the iteration count.
  always_comb begin
    div_rem_init = DIV_D'(num_mag >> S);
    div_low_init = DIV_Q'(num_mag) << (DIV_Q - S);
    div_divisor  = DIV_D'(new_rate);
    div_iters    = CNT_W'(S);
    if (cmd.go_total) begin
      div_rem_init = DIV_D'(cnt_dividend >> COUNT_BITS);
      div_low_init = DIV_Q'(cnt_dividend) << (DIV_Q - COUNT_BITS);
      div_divisor  = {old_rate, 1'b0};
      div_iters    = CNT_W'(COUNT_BITS);
    end else if (cmd.go_step) begin
      div_rem_init = '0;
      div_low_init = DIV_Q'(old_rate) << (DIV_Q - R);
      div_divisor  = DIV_D'(new_rate);
      div_iters    = CNT_W'(R);
    end
  end

  assign div_start = cmd.go_total || cmd.go_step || cmd.go_sample;

  lir_div #(
    .D_W   (DIV_D),
    .Q_W   (DIV_Q),
    .CNT_W (CNT_W)
  ) u_div (
    .clk        (clk),
    .rst        (rst),
    .start      (div_start),
    .rem_init   (div_rem_init),
    .low_init   (div_low_init),
    .divisor_in (div_divisor),
    .iters      (div_iters),
    .busy       (div_busy),
    .quotient   (div_quot),
    .remainder  (div_rem)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      case (cmd.emit_sel)
        EMIT_PASS: begin
          sample_out <= cur_sample;
          last_out   <= status.in_last;
          rate_error <= 1'b0;
        end
        EMIT_ERR: begin
          sample_out <= '0;
          last_out   <= 1'b0;
          rate_error <= 1'b1;
        end
        EMIT_TAIL: begin
          sample_out <= cur_sample;
          last_out   <= sent_last;
          rate_error <= 1'b0;
        end
        default: begin
          sample_out <= interp_val;
          last_out   <= sent_last;
          rate_error <= 1'b0;
        end
      endcase
    end
  end

endmodule

### sv/lir_ctrl.sv
module lir_ctrl import lir_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  lir_status_t status,
  output lir_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_MUL_LEN   = 4'd1;
  localparam logic [3:0] S_TOT_GO    = 4'd2;
  localparam logic [3:0] S_TOT_WAIT  = 4'd3;
  localparam logic [3:0] S_STEP_GO   = 4'd4;
  localparam logic [3:0] S_STEP_WAIT = 4'd5;
  localparam logic [3:0] S_CHECK     = 4'd6;
  localparam logic [3:0] S_MUL       = 4'd7;
  localparam logic [3:0] S_SUM       = 4'd8;
  localparam logic [3:0] S_DIV_GO    = 4'd9;
  localparam logic [3:0] S_DIV_WAIT  = 4'd10;
  localparam logic [3:0] S_EMIT      = 4'd11;
  localparam logic [3:0] S_FINISH    = 4'd12;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [1:0] emit_kind;
  logic [1:0] emit_kind_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      emit_kind <= EMIT_PASS;
    end else begin
      state     <= state_next;
      emit_kind <= emit_kind_next;
    end
  end

  always_comb begin
    cmd            = '0;
    in_ready       = 1'b0;
    state_next     = state;
    emit_kind_next = emit_kind;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          if (status.len_zero) begin
            state_next = S_IDLE;
          end else if (status.pass_mode) begin
            emit_kind_next = EMIT_PASS;
            state_next     = S_EMIT;
          end else if (status.ratio_err) begin
            emit_kind_next = EMIT_ERR;
            state_next     = S_EMIT;
          end else if (status.first_in) begin
            state_next = S_MUL_LEN;
          end else begin
            state_next = S_CHECK;
          end
        end
      end
      S_MUL_LEN: begin
        cmd.mul_len = 1'b1;
        state_next  = S_TOT_GO;
      end
      S_TOT_GO: begin
        cmd.go_total = 1'b1;
        state_next   = S_TOT_WAIT;
      end
      S_TOT_WAIT: begin
        if (!status.div_busy) begin
          cmd.save_total = 1'b1;
          state_next     = S_STEP_GO;
        end
      end
      S_STEP_GO: begin
        cmd.go_step = 1'b1;
        state_next  = S_STEP_WAIT;
      end
      S_STEP_WAIT: begin
        if (!status.div_busy) begin
          cmd.save_step = 1'b1;
          state_next    = S_CHECK;
        end
      end
      S_CHECK: begin
        // Outputs past the last sample wait for that sample; an output
        // whose right neighbor is still to come ends this sample's work.
        if (!status.more) begin
          state_next = S_FINISH;
        end else if (status.tail) begin
          if (status.in_last) begin
            emit_kind_next = EMIT_TAIL;
            state_next     = S_EMIT;
          end else begin
            state_next = S_FINISH;
          end
        end else if (status.interp_ok) begin
          state_next = S_MUL;
        end else begin
          state_next = S_FINISH;
        end
      end
      S_MUL: begin
        cmd.mul_interp = 1'b1;
        state_next     = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_DIV_GO;
      end
      S_DIV_GO: begin
        cmd.go_sample = 1'b1;
        state_next    = S_DIV_WAIT;
      end
      S_DIV_WAIT: begin
        if (!status.div_busy) begin
          emit_kind_next = EMIT_INTERP;
          state_next     = S_EMIT;
        end
      end
      S_EMIT: begin
        cmd.emit_sel = emit_kind;
        if (status.out_free) begin
          cmd.emit = 1'b1;
          case (emit_kind)
            EMIT_PASS: begin
              cmd.pass_finish = 1'b1;
              state_next      = S_IDLE;
            end
            EMIT_ERR: begin
              state_next = S_IDLE;
            end
            default: begin
              cmd.advance = 1'b1;
              state_next  = S_CHECK;
            end
          endcase
        end
      end
      S_FINISH: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
